@@ rtl/core/sct_pkg.sv @@
// Shared types, codes and constants of the shell command tokenizer.
// No dependencies; used by every module under rtl/core.
`default_nettype none

package sct_pkg;

   // Result kinds
   localparam logic [2:0] KindByte  = 3'd0;
   localparam logic [2:0] KindEow   = 3'd1;
   localparam logic [2:0] KindPipe  = 3'd2;
   localparam logic [2:0] KindRedir = 3'd3;
   localparam logic [2:0] KindEol   = 3'd4;

   // Special bytes
   localparam logic [7:0] ChPipe  = 8'h7C;
   localparam logic [7:0] ChGt    = 8'h3E;
   localparam logic [7:0] ChOne   = 8'h31;
   localparam logic [7:0] ChTwo   = 8'h32;
   localparam logic [7:0] ChSq    = 8'h27;
   localparam logic [7:0] ChDq    = 8'h22;
   localparam logic [7:0] ChBs    = 8'h5C;
   localparam logic [7:0] ChSpace = 8'h20;
   localparam logic [7:0] ChTab   = 8'h09;
   localparam logic [7:0] ChCr    = 8'h0D;

   // Escape states
   localparam logic [1:0] EscNone   = 2'd0;
   localparam logic [1:0] EscPlain  = 2'd1;
   localparam logic [1:0] EscDouble = 2'd2;

   // Result slots of one request, in delivery order
   localparam int SlotCount  = 8;
   localparam int SlotRedirA = 0;
   localparam int SlotByteA  = 1;
   localparam int SlotEowA   = 2;
   localparam int SlotPipe   = 3;
   localparam int SlotRedirB = 4;
   localparam int SlotByteB  = 5;
   localparam int SlotEowB   = 6;
   localparam int SlotEol    = 7;

   localparam int QueueDepth = 4;

   // Results of one request in compact form
   typedef struct packed {
      logic [SlotCount-1:0] mask;
      logic [1:0]           fd_a;
      logic                 app_a;
      logic [1:0]           fd_b;
      logic [7:0]           byte_a;
      logic [7:0]           byte_b;
   } sct_rec_type;

endpackage

`default_nettype wire

@@ rtl/core/shell_command_tokenizer.sv @@
// Top level of the shell command tokenizer: front end, record queue, back end.
// Depends on sct_pkg, sct_front, sct_queue and sct_back.
//
//   port group   direction  payload
//   req_*        in         char_in (8), line_end (1)
//   rsp_*        out        kind (3), word_byte (8), redir_fd (2),
//                           redir_append (1), run_last (1)
//
// The front end takes one byte per cycle while the queue has room; a byte
// with no results leaves no record. The back end delivers one result per
// cycle while rsp_ready is high, so a byte that causes n results keeps the
// output busy until all n are delivered. Output stalls fill the queue of
// QUEUE_DEPTH records, then req_ready drops. Reset is synchronous and returns
// the quoting state to the start of a line and empties the queue.
`default_nettype none

module shell_command_tokenizer #(
   parameter int QUEUE_DEPTH = sct_pkg::QueueDepth
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_char_in,
   input  wire logic       req_line_end,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [2:0]      rsp_kind,
   output logic [7:0]      rsp_word_byte,
   output logic [1:0]      rsp_redir_fd,
   output logic            rsp_redir_append,
   output logic            rsp_run_last
);

   sct_pkg::sct_rec_type front_rec;
   sct_pkg::sct_rec_type q_rec;
   logic front_has;
   logic take;
   logic q_push_ready;
   logic q_pop_valid;
   logic q_pop_ready;

   assign req_ready = q_push_ready;
   assign take      = req_valid && req_ready;

   sct_front u_front (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .char_in    (req_char_in),
      .line_end   (req_line_end),
      .rec        (front_rec),
      .has_result (front_has)
   );

   sct_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (take && front_has),
      .push_data  (front_rec),
      .push_ready (q_push_ready),
      .pop_valid  (q_pop_valid),
      .pop_data   (q_rec),
      .pop_ready  (q_pop_ready)
   );

   sct_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (q_pop_valid),
      .pop_data         (q_rec),
      .pop_ready        (q_pop_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_word_byte    (rsp_word_byte),
      .rsp_redir_fd     (rsp_redir_fd),
      .rsp_redir_append (rsp_redir_append),
      .rsp_run_last     (rsp_run_last)
   );

   // Back end takes a new record only once the current one is fully delivered
   a_pop_after_last: assert property (@(posedge clock) disable iff (reset)
      (q_pop_valid && q_pop_ready) |-> (!rsp_valid || (rsp_ready && rsp_run_last)))
      else $error("record loaded while results still pending");

   // End of line is always the final result of its request
   a_eol_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == sct_pkg::KindEol)) |-> rsp_run_last)
      else $error("end of line not marked last");

   // Only redirects carry a descriptor or append flag
   a_redir_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind != sct_pkg::KindRedir)) |->
      ((rsp_redir_fd == 2'd0) && !rsp_redir_append))
      else $error("redirect fields set on non-redirect result");

   // A byte that ends the line always yields a record
   a_eol_pushed: assert property (@(posedge clock) disable iff (reset)
      (take && req_line_end) |-> front_has)
      else $error("line end produced no record");

endmodule

`default_nettype wire

@@ rtl/core/sct_front.sv @@
// Front end: accepts bytes, tracks quoting state and turns each byte into
// a result record. Depends on sct_pkg.
`default_nettype none

module sct_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               take,
   input  wire logic [7:0]         char_in,
   input  wire logic               line_end,
   output sct_pkg::sct_rec_type    rec,
   output logic                    has_result
);

   logic       single_ff, single_in;
   logic       double_ff, double_in;
   logic [1:0] esc_ff, esc_in;
   logic       redir_ff, redir_in;
   logic [1:0] pfd_ff, pfd_in;
   logic       held_v_ff, held_v_in;
   logic [7:0] held_b_ff, held_b_in;
   logic       started_ff, started_in;

   // Classify the byte and compute next state and results
   always_comb begin
      logic       hv;
      logic [7:0] hb;
      logic       ws;
      logic       sq;
      logic       dq;
      logic [1:0] esc;
      logic       pend;
      logic [1:0] pfd;
      logic       do_plain;
      logic       quoted;
      logic       space;
      logic [1:0] fd;
      sct_pkg::sct_rec_type r;

      hv       = held_v_ff;
      hb       = held_b_ff;
      ws       = started_ff;
      sq       = single_ff;
      dq       = double_ff;
      esc      = sct_pkg::EscNone;
      pend     = 1'b0;
      pfd      = 2'd0;
      do_plain = 1'b0;
      quoted   = single_ff | double_ff;
      space    = (char_in == sct_pkg::ChSpace) ||
                 ((char_in >= sct_pkg::ChTab) && (char_in <= sct_pkg::ChCr));
      fd       = 2'd0;
      r        = '0;
      r.fd_a   = pfd_ff;
      r.byte_a = held_b_ff;

      if (redir_ff) begin
         r.mask[sct_pkg::SlotRedirA] = 1'b1;
         r.app_a  = (char_in == sct_pkg::ChGt);
         do_plain = (char_in != sct_pkg::ChGt);
      end else if ((esc_ff == sct_pkg::EscPlain) ||
                   ((esc_ff == sct_pkg::EscDouble) &&
                    ((char_in == sct_pkg::ChBs) || (char_in == sct_pkg::ChDq)))) begin
         if (hv) begin
            r.mask[sct_pkg::SlotByteA] = 1'b1;
            ws = 1'b1;
         end
         hb = char_in;
         hv = 1'b1;
      end else begin
         do_plain = 1'b1;
      end

      if (do_plain) begin
         if (space && !quoted) begin
            r.mask[sct_pkg::SlotByteA] = hv;
            r.mask[sct_pkg::SlotEowA]  = hv;
            hv = 1'b0;
            ws = 1'b0;
         end else if ((char_in == sct_pkg::ChSq) && !double_ff) begin
            sq = !single_ff;
         end else if ((char_in == sct_pkg::ChDq) && !single_ff) begin
            dq = !double_ff;
         end else if ((char_in == sct_pkg::ChBs) && !quoted && !line_end) begin
            esc = sct_pkg::EscPlain;
         end else if ((char_in == sct_pkg::ChBs) && double_ff) begin
            if (!line_end) begin
               esc = sct_pkg::EscDouble;
            end
         end else if ((char_in == sct_pkg::ChPipe) && !quoted) begin
            r.mask[sct_pkg::SlotByteA] = hv;
            r.mask[sct_pkg::SlotEowA]  = hv;
            r.mask[sct_pkg::SlotPipe]  = 1'b1;
            hv = 1'b0;
            ws = 1'b0;
         end else if ((char_in == sct_pkg::ChGt) && !quoted) begin
            // A trailing '1' or '2' of the word becomes the descriptor
            if (hv && ((hb == sct_pkg::ChOne) || (hb == sct_pkg::ChTwo))) begin
               fd = hb[1:0];
               r.mask[sct_pkg::SlotEowA] = ws;
            end else begin
               r.mask[sct_pkg::SlotByteA] = hv;
               r.mask[sct_pkg::SlotEowA]  = hv;
            end
            hv = 1'b0;
            ws = 1'b0;
            if (line_end) begin
               r.mask[sct_pkg::SlotRedirB] = 1'b1;
               r.fd_b = fd;
            end else begin
               pend = 1'b1;
               pfd  = fd;
            end
         end else begin
            // Ordinary byte, or a kept backslash
            if (hv) begin
               r.mask[sct_pkg::SlotByteA] = 1'b1;
               ws = 1'b1;
            end
            hb = char_in;
            hv = 1'b1;
         end
      end

      // Close the line: flush the held byte, end the word, end the line
      if (line_end) begin
         r.mask[sct_pkg::SlotByteB] = hv;
         r.mask[sct_pkg::SlotEowB]  = hv;
         r.mask[sct_pkg::SlotEol]   = 1'b1;
      end
      r.byte_b = hb;

      rec        = r;
      has_result = |r.mask;

      single_in  = line_end ? 1'b0 : sq;
      double_in  = line_end ? 1'b0 : dq;
      esc_in     = line_end ? sct_pkg::EscNone : esc;
      redir_in   = line_end ? 1'b0 : pend;
      pfd_in     = line_end ? 2'd0 : pfd;
      held_v_in  = line_end ? 1'b0 : hv;
      held_b_in  = line_end ? 8'd0 : hb;
      started_in = line_end ? 1'b0 : ws;
   end

   // Advance state on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         single_ff  <= 1'b0;
         double_ff  <= 1'b0;
         esc_ff     <= sct_pkg::EscNone;
         redir_ff   <= 1'b0;
         pfd_ff     <= 2'd0;
         held_v_ff  <= 1'b0;
         held_b_ff  <= 8'd0;
         started_ff <= 1'b0;
      end else if (take) begin
         single_ff  <= single_in;
         double_ff  <= double_in;
         esc_ff     <= esc_in;
         redir_ff   <= redir_in;
         pfd_ff     <= pfd_in;
         held_v_ff  <= held_v_in;
         held_b_ff  <= held_b_in;
         started_ff <= started_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/sct_queue.sv @@
// Short register queue of result records between front and back end.
// Depends on sct_pkg for the record type.
`default_nettype none

module sct_queue #(
   parameter int DEPTH = sct_pkg::QueueDepth
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   input  wire sct_pkg::sct_rec_type push_data,
   output logic                      push_ready,
   output logic                      pop_valid,
   output sct_pkg::sct_rec_type      pop_data,
   input  wire logic                 pop_ready
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   sct_pkg::sct_rec_type rec_ff [DEPTH];
   logic [PtrW-1:0] wr_ff, wr_in;
   logic [PtrW-1:0] rd_ff, rd_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            push;
   logic            pop;

   assign push_ready = (cnt_ff != CntW'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = rec_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Wrap pointers and track fill level
   always_comb begin
      wr_in  = (wr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      rd_in  = (rd_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_in;
         end
         if (pop) begin
            rd_ff <= rd_in;
         end
         cnt_ff <= cnt_in;
      end
   end

   // Store the record
   always_ff @(posedge clock) begin
      if (push) begin
         rec_ff[wr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/sct_back.sv @@
// Back end: walks the slots of one record and delivers one result a cycle while rsp_ready is high.
// Depends on sct_pkg.
`default_nettype none

module sct_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 pop_valid,
   input  wire sct_pkg::sct_rec_type pop_data,
   output logic                      pop_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [2:0]                rsp_kind,
   output logic [7:0]                rsp_word_byte,
   output logic [1:0]                rsp_redir_fd,
   output logic                      rsp_redir_append,
   output logic                      rsp_run_last
);

   sct_pkg::sct_rec_type cur_ff;
   logic [sct_pkg::SlotCount-1:0] low;
   logic [sct_pkg::SlotCount-1:0] rest;

   // Pick the lowest pending slot
   assign low  = cur_ff.mask & (~cur_ff.mask + 1'b1);
   assign rest = cur_ff.mask & ~low;

   assign rsp_valid    = |cur_ff.mask;
   assign rsp_run_last = rsp_valid && (rest == '0);
   assign pop_ready    = !rsp_valid || (rsp_ready && (rest == '0));

   // Decode the slot into a result
   always_comb begin
      rsp_kind         = sct_pkg::KindEol;
      rsp_word_byte    = 8'd0;
      rsp_redir_fd     = 2'd0;
      rsp_redir_append = 1'b0;
      if (low[sct_pkg::SlotRedirA]) begin
         rsp_kind         = sct_pkg::KindRedir;
         rsp_redir_fd     = cur_ff.fd_a;
         rsp_redir_append = cur_ff.app_a;
      end else if (low[sct_pkg::SlotByteA]) begin
         rsp_kind      = sct_pkg::KindByte;
         rsp_word_byte = cur_ff.byte_a;
      end else if (low[sct_pkg::SlotEowA] || low[sct_pkg::SlotEowB]) begin
         rsp_kind = sct_pkg::KindEow;
      end else if (low[sct_pkg::SlotPipe]) begin
         rsp_kind = sct_pkg::KindPipe;
      end else if (low[sct_pkg::SlotRedirB]) begin
         rsp_kind     = sct_pkg::KindRedir;
         rsp_redir_fd = cur_ff.fd_b;
      end else if (low[sct_pkg::SlotByteB]) begin
         rsp_kind      = sct_pkg::KindByte;
         rsp_word_byte = cur_ff.byte_b;
      end
   end

   // Load a new record or drop the delivered slot; payload needs no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff.mask <= '0;
      end else if (pop_ready) begin
         cur_ff.mask <= pop_valid ? pop_data.mask : '0;
      end else if (rsp_ready) begin
         cur_ff.mask <= rest;
      end
      if (pop_ready && pop_valid) begin
         cur_ff.fd_a   <= pop_data.fd_a;
         cur_ff.app_a  <= pop_data.app_a;
         cur_ff.fd_b   <= pop_data.fd_b;
         cur_ff.byte_a <= pop_data.byte_a;
         cur_ff.byte_b <= pop_data.byte_b;
      end
   end

endmodule

`default_nettype wire
